/* design/timestamped_message_queue_top_defines.svh */
// assertion macros for the timestamped message queue
// no dependencies; included by the top level
`ifndef TIMESTAMPED_MESSAGE_QUEUE_TOP_DEFINES_SVH
`define TIMESTAMPED_MESSAGE_QUEUE_TOP_DEFINES_SVH

// same-cycle implication
`define TMQ_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TMQ_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* design/tmq_pkg.sv */
// shared types and constants for the timestamped message queue
// no dependencies
package tmq_pkg;

  localparam int QUEUE_DEPTH_DEF = 10;
  localparam int MAX_BYTES_DEF   = 64;
  localparam int TIME_BYTES      = 8;
  localparam int LEN_W           = 7;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_LENGTH = 2'd3
  } status_t;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_COMMIT,
    S_POP_LD,
    S_POP_OUT
  } state_t;

endpackage

/* design/timestamped_message_queue_top.sv */
// Ring queue of timestamped messages. A push word is taken every cycle while busy is low; a
// message's final word moves the block to its commit state, in which the stamp is computed and
// the slot record is written. A pop reads the slot record memory, then does the 64-bit
// elapsed-time subtract, then gives one word per cycle, the time words from the elapsed time
// and the rest from the payload memory, which has a single read port. A pop on an empty queue
// answers in the next cycle. Every result is shown for exactly one cycle with strobe high and
// cannot be held off, so the receiver must take a word in every cycle that strobe is high.
// depends on tmq_pkg and timestamped_message_queue_top_defines.svh
module timestamped_message_queue_top #(
  parameter int QUEUE_DEPTH = tmq_pkg::QUEUE_DEPTH_DEF,
  parameter int MAX_BYTES   = tmq_pkg::MAX_BYTES_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic                      operation,
  input  logic [7:0]                data_byte,
  input  logic                      last_byte,
  input  logic [63:0]               now,
  output logic                      strobe,
  output logic [7:0]                out_byte,
  output logic                      out_last,
  output logic [1:0]                status,
  output logic [tmq_pkg::LEN_W-1:0] msg_length
);
  import tmq_pkg::*;

  localparam int SLOT_W    = $clog2(QUEUE_DEPTH);
  localparam int IDX_W     = $clog2(MAX_BYTES);
  localparam int CNT_W     = $clog2(MAX_BYTES + 2);
  localparam int SLEN_W    = $clog2(MAX_BYTES + 1);
  localparam int ADDR_W    = SLOT_W + IDX_W;
  localparam int PAY_DEPTH = QUEUE_DEPTH << IDX_W;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0]  MAX_CNT   = CNT_W'(MAX_BYTES);
  localparam logic [CNT_W-1:0]  OVF_CNT   = CNT_W'(MAX_BYTES + 1);
  localparam logic [CNT_W-1:0]  TIME_CNT  = CNT_W'(TIME_BYTES);

  typedef struct packed {
    logic [SLEN_W-1:0] len;
    logic [63:0]       stamp;
  } slot_t;

  state_t state, state_next;

  logic [SLOT_W-1:0] head, tail;
  logic              empty_flag;
  logic [CNT_W-1:0]  fill_count, fill_next;
  logic [63:0]       time_asm, time_asm_next;
  logic              dropping, dropping_next;
  logic [63:0]       now_q;
  status_t           commit_status;
  logic [SLEN_W-1:0] commit_len;
  logic [63:0]       elapsed;
  logic [SLEN_W-1:0] pop_len;
  logic [IDX_W-1:0]  pop_idx;
  logic              pop_done;

  logic              res_valid, res_last, res_pop, res_time;
  status_t           res_status;
  logic [SLEN_W-1:0] res_len;
  logic [2:0]        res_tsel;

  logic [7:0]        pay_mem [PAY_DEPTH];
  logic [7:0]        pay_rd;
  slot_t             slot_mem [QUEUE_DEPTH];
  slot_t             slot_rd;

  logic              accept, push_acc, pop_acc;
  logic              queue_full, drop_now, pay_we, len_bad;
  status_t           push_status;
  logic [SLOT_W-1:0] head_inc, tail_inc;

  assign accept   = start && !busy;
  assign push_acc = accept && (op_t'(operation) == OP_PUSH);
  assign pop_acc  = accept && (op_t'(operation) == OP_POP);

  assign queue_full = (head == tail) && !empty_flag;
  assign head_inc   = (head == LAST_SLOT) ? '0 : head + SLOT_W'(1);
  assign tail_inc   = (tail == LAST_SLOT) ? '0 : tail + SLOT_W'(1);
  assign pop_done   = (SLEN_W'(pop_idx) + SLEN_W'(1)) == pop_len;

  // push word bookkeeping
  always_comb begin
    drop_now      = dropping || ((fill_count == '0) && queue_full);
    pay_we        = 1'b0;
    time_asm_next = time_asm;
    if (fill_count >= MAX_CNT) begin
      fill_next     = OVF_CNT;
      dropping_next = 1'b1;
    end else begin
      fill_next     = fill_count + CNT_W'(1);
      dropping_next = drop_now;
      if (!drop_now) begin
        pay_we = push_acc;
        if (fill_count < TIME_CNT) begin
          time_asm_next = time_asm | ({56'd0, data_byte} << {fill_count[2:0], 3'b000});
        end
      end
    end
    len_bad = (fill_next > MAX_CNT) || (fill_next < TIME_CNT);
    priority if (len_bad) begin
      push_status = ST_LENGTH;
    end else if (dropping_next) begin
      push_status = ST_FULL;
    end else begin
      push_status = ST_OK;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (pop_acc && !empty_flag) begin
          state_next = S_POP_LD;
        end else if (push_acc && last_byte) begin
          state_next = S_COMMIT;
        end
      end
      S_COMMIT:  state_next = S_IDLE;
      S_POP_LD:  state_next = S_POP_OUT;
      S_POP_OUT: begin
        if (pop_done) begin
          state_next = S_IDLE;
        end
      end
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    busy       = (state != S_IDLE);
    strobe     = res_valid;
    out_last   = res_last;
    status     = res_status;
    msg_length = LEN_W'(res_len);
    if (!res_pop) begin
      out_byte = 8'h00;
    end else if (res_time) begin
      out_byte = elapsed[{res_tsel, 3'b000} +: 8];
    end else begin
      out_byte = pay_rd;
    end
  end

  // payload memory
  always_ff @(posedge clk) begin
    if (pay_we) begin
      pay_mem[{tail, fill_count[IDX_W-1:0]}] <= data_byte;
    end
    pay_rd <= pay_mem[ADDR_W'({head, pop_idx})];
  end

  // slot record memory
  always_ff @(posedge clk) begin
    if (state == S_COMMIT && commit_status == ST_OK) begin
      slot_mem[tail] <= '{len: commit_len, stamp: now_q - time_asm};
    end
    slot_rd <= slot_mem[head];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head       <= '0;
      tail       <= '0;
      empty_flag <= 1'b1;
      fill_count <= '0;
      time_asm   <= '0;
      dropping   <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      state     <= state_next;
      res_valid <= 1'b0;

      if (push_acc) begin
        now_q    <= now;
        time_asm <= time_asm_next;
        if (last_byte) begin
          commit_status <= push_status;
          commit_len    <= SLEN_W'(fill_next);
          fill_count    <= '0;
          dropping      <= 1'b0;
        end else begin
          fill_count <= fill_next;
          dropping   <= dropping_next;
        end
      end

      if (pop_acc) begin
        now_q <= now;
        if (empty_flag) begin
          res_valid  <= 1'b1;
          res_last   <= 1'b1;
          res_status <= ST_EMPTY;
          res_len    <= '0;
          res_pop    <= 1'b0;
        end
      end

      unique case (state)
        S_COMMIT: begin
          res_valid  <= 1'b1;
          res_last   <= 1'b1;
          res_status <= commit_status;
          res_len    <= '0;
          res_pop    <= 1'b0;
          time_asm   <= '0;
          if (commit_status == ST_OK) begin
            tail       <= tail_inc;
            empty_flag <= 1'b0;
          end
        end
        S_POP_LD: begin
          elapsed <= now_q - slot_rd.stamp;
          pop_len <= slot_rd.len;
          pop_idx <= '0;
        end
        S_POP_OUT: begin
          res_valid  <= 1'b1;
          res_last   <= pop_done;
          res_status <= ST_OK;
          res_len    <= pop_len;
          res_pop    <= 1'b1;
          res_time   <= int'(pop_idx) < TIME_BYTES;
          res_tsel   <= pop_idx[2:0];
          pop_idx    <= pop_idx + IDX_W'(1);
          if (pop_done) begin
            head       <= head_inc;
            empty_flag <= (head_inc == tail);
          end
        end
        default: begin
        end
      endcase
    end
  end

`include "timestamped_message_queue_top_defines.svh"

  `TMQ_ASSERT_NXT(a_commit_reports, clk, rst, state == S_COMMIT, strobe && out_last, "commit gave no status word")
  `TMQ_ASSERT_NXT(a_empty_pop, clk, rst, pop_acc && empty_flag, strobe && status == ST_EMPTY, "empty pop not reported")
  `TMQ_ASSERT_IMP(a_empty_ptrs, clk, rst, empty_flag, head == tail, "empty flag with pointers apart")
  `TMQ_ASSERT_NXT(a_pop_end, clk, rst, state == S_POP_OUT && pop_done, strobe && out_last && state == S_IDLE, "pop run did not end")

endmodule

/* verif/tb_top.sv */
// testbench for the timestamped message queue: directed table then random message traffic
// word-level predictor and result checker live here; depends on tmq_pkg and the top level
module tb_top;
  import tmq_pkg::*;

  localparam int QD          = QUEUE_DEPTH_DEF;
  localparam int MB          = MAX_BYTES_DEF;
  localparam int RAND_WORDS  = 350;
  localparam int STALL_LIMIT = 4000;

  typedef struct packed {
    logic [7:0]       b;
    logic             last;
    status_t          st;
    logic [LEN_W-1:0] len;
  } out_word_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  data;
    logic        last;
    logic [63:0] tnow;
    logic        fixed;
    status_t     st;
  } row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             operation = 1'b0;
  logic [7:0]       data_byte = 8'h00;
  logic             last_byte = 1'b0;
  logic [63:0]      now = 64'd0;
  logic             busy;
  logic             strobe;
  logic [7:0]       out_byte;
  logic             out_last;
  logic [1:0]       status;
  logic [LEN_W-1:0] msg_length;

  // typed-in expectation travels with the word
  logic    fixed_chk = 1'b0;
  status_t fixed_st = ST_OK;

  // predictor state
  logic [7:0]       body_mem [QD*MB];
  logic [63:0]      stamp_mem [QD];
  logic [LEN_W-1:0] len_mem [QD];
  int               head = 0;
  int               tail = 0;
  bit               is_empty = 1'b1;
  int               fill = 0;
  logic [63:0]      time_acc = 64'd0;
  bit               dropping = 1'b0;
  int               held = 0;

  out_word_t step_words [$];
  out_word_t words_due [$];
  out_word_t want;
  row_t      plan [$];

  int          errors = 0;
  int          sent = 0;
  int          n_checked = 0;
  int          n_commit = 0;
  int          n_full = 0;
  int          n_len = 0;
  int          n_empty = 0;
  int          stall_cycles = 0;
  bit          steady = 1'b0;
  logic [63:0] clock_base;

  timestamped_message_queue_top #(
    .QUEUE_DEPTH(QD),
    .MAX_BYTES  (MB)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .operation (operation),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .now       (now),
    .strobe    (strobe),
    .out_byte  (out_byte),
    .out_last  (out_last),
    .status    (status),
    .msg_length(msg_length)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic predict_word(op_t op, logic [7:0] d, logic l, logic [63:0] tnow);
    status_t     st;
    int          n;
    logic [63:0] elapsed;
    logic [7:0]  b;
    step_words.delete();
    if (op == OP_PUSH) begin
      if (fill == 0 && head == tail && !is_empty) dropping = 1'b1;
      if (fill >= MB) begin
        fill = MB + 1;
        dropping = 1'b1;
      end else begin
        if (!dropping) begin
          if (fill < TIME_BYTES) time_acc[8*fill +: 8] = d;
          body_mem[tail*MB + fill] = d;
        end
        fill++;
      end
      if (l) begin
        if (fill > MB || fill < TIME_BYTES) begin
          st = ST_LENGTH;
          n_len++;
        end else if (dropping) begin
          st = ST_FULL;
          n_full++;
        end else begin
          stamp_mem[tail] = tnow - time_acc;
          len_mem[tail] = LEN_W'(fill);
          tail = (tail + 1 == QD) ? 0 : tail + 1;
          is_empty = 1'b0;
          held++;
          n_commit++;
          st = ST_OK;
        end
        fill = 0;
        time_acc = 64'd0;
        dropping = 1'b0;
        step_words.push_back({8'h00, 1'b1, st, {LEN_W{1'b0}}});
      end
    end else if (is_empty) begin
      n_empty++;
      step_words.push_back({8'h00, 1'b1, ST_EMPTY, {LEN_W{1'b0}}});
    end else begin
      n = int'(len_mem[head]);
      elapsed = tnow - stamp_mem[head];
      for (int i = 0; i < n; i++) begin
        b = (i < TIME_BYTES) ? elapsed[8*i +: 8] : body_mem[head*MB + i];
        step_words.push_back({b, (i + 1 == n), ST_OK, n[LEN_W-1:0]});
      end
      len_mem[head] = '0;
      head = (head + 1 == QD) ? 0 : head + 1;
      is_empty = (head == tail);
      held--;
    end
  endtask

  // result check, then prediction for the word accepted at this edge
  always @(posedge clk) begin
    if (!rst) begin
      if (strobe) begin
        if (words_due.size() == 0) begin
          $display("%0t: unexpected result word: byte %02h last %0d status %0d length %0d",
                   $time, out_byte, out_last, status, msg_length);
          errors++;
        end else begin
          want = words_due.pop_front();
          n_checked++;
          if (out_byte !== want.b) begin
            $display("%0t: out_byte expected %02h got %02h", $time, want.b, out_byte);
            errors++;
          end
          if (out_last !== want.last) begin
            $display("%0t: out_last expected %0d got %0d", $time, want.last, out_last);
            errors++;
          end
          if (status !== want.st) begin
            $display("%0t: status expected %0d got %0d", $time, want.st, status);
            errors++;
          end
          if (msg_length !== want.len) begin
            $display("%0t: msg_length expected %0d got %0d", $time, want.len, msg_length);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        predict_word(op_t'(operation), data_byte, last_byte, now);
        if (fixed_chk) begin
          step_words.delete();
          step_words.push_back({8'h00, 1'b1, fixed_st, {LEN_W{1'b0}}});
        end
        foreach (step_words[i]) words_due.push_back(step_words[i]);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || strobe || (start && !busy)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic [63:0] next_now();
    clock_base = clock_base + 64'($urandom_range(1, 500));
    if ($urandom_range(0, 7) == 0) return {$urandom, $urandom};
    return clock_base;
  endfunction

  function automatic row_t row(op_t op, logic [7:0] d, logic l, logic [63:0] t,
                               logic fx, status_t st);
    return {op, d, l, t, fx, st};
  endfunction

  task automatic offer_word(op_t op, logic [7:0] d, logic l, logic [63:0] t,
                            logic fx, status_t st);
    while (!steady && $urandom_range(0, 99) < 37) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start     <= 1'b1;
    operation <= op;
    data_byte <= d;
    last_byte <= l;
    now       <= t;
    fixed_chk <= fx;
    fixed_st  <= st;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
  endtask

  task automatic push_msg(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 11) == 0)
        offer_word(OP_POP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), next_now(),
                   1'b0, ST_OK);
      offer_word(OP_PUSH, 8'($urandom_range(0, 255)), i == n - 1, next_now(), 1'b0, ST_OK);
    end
  endtask

  initial begin
    int  r;
    int  pop_p;
    int  goal;
    bit  draining;
    draining = 1'b0;
    clock_base = {$urandom, $urandom};

    // empty pop, too short, minimum length with all-ones stamp, pop during push
    plan.push_back(row(OP_POP,  8'h00, 1'b0, 64'd0, 1'b1, ST_EMPTY));
    plan.push_back(row(OP_PUSH, 8'h00, 1'b1, 64'd5, 1'b1, ST_LENGTH));
    for (int i = 0; i < 7; i++)
      plan.push_back(row(OP_PUSH, 8'hFF, 1'b0, 64'd0, 1'b0, ST_OK));
    plan.push_back(row(OP_PUSH, 8'hFF, 1'b1, 64'd0, 1'b1, ST_OK));
    for (int i = 0; i < 4; i++)
      plan.push_back(row(OP_PUSH, 8'h00, 1'b0, 64'h0123_4567_89AB_CDEF, 1'b0, ST_OK));
    plan.push_back(row(OP_POP,  8'hFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, ST_OK));
    plan.push_back(row(OP_PUSH, 8'h80, 1'b0, 64'd1, 1'b0, ST_OK));
    plan.push_back(row(OP_PUSH, 8'h7F, 1'b0, 64'd2, 1'b0, ST_OK));
    plan.push_back(row(OP_PUSH, 8'h01, 1'b0, 64'd3, 1'b0, ST_OK));
    plan.push_back(row(OP_PUSH, 8'hFE, 1'b0, 64'd4, 1'b0, ST_OK));
    plan.push_back(row(OP_PUSH, 8'h55, 1'b1, 64'h8000_0000_0000_0000, 1'b1, ST_OK));
    plan.push_back(row(OP_POP,  8'h00, 1'b0, 64'd0, 1'b0, ST_OK));
    plan.push_back(row(OP_POP,  8'h00, 1'b0, 64'd7, 1'b1, ST_EMPTY));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i])
      offer_word(plan[i].op, plan[i].data, plan[i].last, plan[i].tnow,
                 plan[i].fixed, plan[i].st);

    goal = sent + RAND_WORDS;
    while (sent < goal) begin
      if (held == QD && $urandom_range(0, 2) == 0) draining = 1'b1;
      if (held == 0) draining = 1'b0;
      steady = (sent >= 150 && sent < 240);
      pop_p = draining ? 55 : 12;
      r = $urandom_range(0, 99);
      if (r < pop_p)
        offer_word(OP_POP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), next_now(),
                   1'b0, ST_OK);
      else if (r < pop_p + 5)
        offer_word(OP_PUSH, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), next_now(),
                   1'b0, ST_OK);
      else if (r < pop_p + 9)
        push_msg($urandom_range(1, TIME_BYTES - 1));
      else if (r < pop_p + 11)
        push_msg($urandom_range(MB + 1, MB + 3));
      else if (r < pop_p + 13)
        push_msg(MB);
      else if ($urandom_range(0, 3) == 0)
        push_msg($urandom_range(11, 20));
      else
        push_msg($urandom_range(TIME_BYTES, 10));
    end
    steady = 1'b0;
    start <= 1'b0;

    while (words_due.size() != 0) @(posedge clk);
    repeat (MB + 8) @(posedge clk);

    if (words_due.size() != 0) begin
      $display("%0t: %0d expected result words never arrived", $time, words_due.size());
      errors++;
    end
    $display("sent %0d words, checked %0d result words, %0d mismatches", sent, n_checked,
             errors);
    $display("commits %0d, full drops %0d, length drops %0d, empty pops %0d",
             n_commit, n_full, n_len, n_empty);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
